[rtl/hvn_pkg.sv]
`default_nettype none
package hvn_pkg;

    localparam int IDX_W     = 16;
    localparam int H_W       = 8;
    localparam int N_W       = 16;
    localparam int CX_W      = 9;
    localparam int SP_W      = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_COUNT_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COUNT_Z = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SPACING = 2'd2;

    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_READ  = 1'b1;

    // magnitude of one summed component, its square, the sum of squares
    localparam int MAG_W  = 22;
    localparam int SQ_W   = 44;
    localparam int SUM_W  = 46;
    // accumulator of the exact rounding search
    localparam int NACC_W = 80;
    localparam int NRES_W = 15;
    localparam int NB     = 7;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_FETCH,
        ST_SUM,
        ST_SQ,
        ST_NORM,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic              start;
        logic [SQ_W-1:0]   sq;
        logic [SUM_W-1:0]  s;
    } t_norm_cmd;

    typedef struct packed {
        logic              done;
        logic [NRES_W-1:0] m;
    } t_norm_sts;

endpackage
`default_nettype wire

[rtl/hvn_if.sv]
`default_nettype none
interface hvn_req_if;
    import hvn_pkg::*;
    logic             valid;
    logic             ready;
    logic             req_type;
    logic [IDX_W-1:0] vertex_index;
    logic [H_W-1:0]   height_sample;
    modport source (output valid, output req_type, output vertex_index,
                    output height_sample, input ready);
    modport sink   (input valid, input req_type, input vertex_index,
                    input height_sample, output ready);
endinterface

interface hvn_res_if;
    import hvn_pkg::*;
    logic                  valid;
    logic                  ready;
    logic signed [N_W-1:0] normal_x;
    logic signed [N_W-1:0] normal_y;
    logic signed [N_W-1:0] normal_z;
    logic [IDX_W-1:0]      vertex_echo;
    logic                  index_error;
    modport source (output valid, output normal_x, output normal_y, output normal_z,
                    output vertex_echo, output index_error, input ready);
    modport sink   (input valid, input normal_x, input normal_y, input normal_z,
                    input vertex_echo, input index_error, output ready);
endinterface

interface hvn_cfg_if;
    import hvn_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_DAT_W-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

[rtl/hvn_store.sv]
`default_nettype none
module hvn_store #(
    parameter int DEPTH = 65536
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0]   i_wr_addr,
    input  wire logic [hvn_pkg::H_W-1:0]    i_wr_data,
    input  wire logic                       i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0]   i_rd_addr,
    output logic      [hvn_pkg::H_W-1:0]    o_rd_data,
    output logic                            o_busy
);
    import hvn_pkg::*;

    localparam int AW = $clog2(DEPTH);

    logic [H_W-1:0] r_mem [DEPTH];
    logic [H_W-1:0] r_rd_data;
    logic [AW-1:0]  r_clr_addr;
    logic           r_clearing;

    // sweep zeros through the whole store after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clearing) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == AW'(DEPTH - 1)) begin
                r_clearing <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clearing) begin
            r_mem[r_clr_addr] <= '0;
        end else if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
    assign o_busy    = r_clearing;

endmodule
`default_nettype wire

[rtl/hvn_div.sv]
`default_nettype none
module hvn_div #(
    parameter int NW = 16,
    parameter int DW = 9
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic [NW-1:0] i_num,
    input  wire logic [DW-1:0] i_den,
    output logic               o_done,
    output logic [NW-1:0]      o_quot,
    output logic [DW-1:0]      o_rem
);
    localparam int CNW = $clog2(NW + 1);

    logic [NW-1:0]  r_work;
    logic [DW-1:0]  r_rem;
    logic [DW-1:0]  r_den;
    logic [CNW-1:0] r_cnt;
    logic           r_busy;
    logic           r_done;
    logic [DW:0]    n_trial;
    logic           n_ge;
    logic [DW:0]    n_diff;

    // restoring division, one quotient bit a cycle
    always_comb begin
        n_trial = {r_rem, r_work[NW-1]};
        n_ge    = n_trial >= {1'b0, r_den};
        n_diff  = n_trial - {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNW'(NW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_work <= i_num;
            r_rem  <= '0;
            r_den  <= i_den;
        end else if (r_busy) begin
            r_work <= {r_work[NW-2:0], n_ge};
            r_rem  <= n_ge ? n_diff[DW-1:0] : n_trial[DW-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_work;
    assign o_rem  = r_rem;

endmodule
`default_nettype wire

[rtl/hvn_norm.sv]
`default_nettype none
module hvn_norm (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire hvn_pkg::t_norm_cmd i_cmd,
    output hvn_pkg::t_norm_sts      o_sts
);
    import hvn_pkg::*;

    localparam int KW = $clog2(NRES_W);

    logic signed [NACC_W-1:0] r_sv;
    logic signed [NACC_W-1:0] r_r;
    logic signed [NACC_W-1:0] r_s1;
    logic signed [NACC_W-1:0] r_s2;
    logic signed [NACC_W-1:0] r_t;
    logic signed [NACC_W-1:0] r_u;
    logic signed [NACC_W-1:0] n_trial;
    logic signed [NACC_W-1:0] n_sv;
    logic [NRES_W-1:0]        r_m;
    logic [KW-1:0]            r_k;
    logic                     r_busy;
    logic                     r_phase;
    logic                     r_done;
    logic [4:0]               n_sh0;
    logic [4:0]               n_sh1;
    logic [4:0]               n_sh2;

    // Greedy bit search for the largest m with s*(2m-1)^2 <= c^2 * 2^30.
    // r_s1 tracks s*t and r_s2 tracks s*t^2 for t = 2m-1, so each trial
    // bit costs only shifts and adds.
    always_comb begin
        n_sv    = signed'(NACC_W'(i_cmd.s));
        n_sh0   = 5'(r_k) + 5'd1;
        n_sh1   = 5'(r_k) + 5'd2;
        n_sh2   = 5'({r_k, 1'b0}) + 5'd2;
        n_trial = r_t + r_u;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_phase <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_cmd.start) begin
                r_busy  <= 1'b1;
                r_phase <= 1'b0;
            end else if (r_busy) begin
                r_phase <= ~r_phase;
                if (r_phase && r_k == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_sv <= n_sv;
            r_s2 <= n_sv;
            r_s1 <= -n_sv;
            r_r  <= signed'(NACC_W'(i_cmd.sq)) <<< 30;
            r_m  <= '0;
            r_k  <= KW'(NRES_W - 1);
        end else if (r_busy) begin
            if (!r_phase) begin
                r_t <= r_s2 + (r_s1 <<< n_sh1);
                r_u <= r_sv <<< n_sh2;
            end else begin
                if (n_trial <= r_r) begin
                    r_s2     <= n_trial;
                    r_s1     <= r_s1 + (r_sv <<< n_sh0);
                    r_m[r_k] <= 1'b1;
                end
                r_k <= r_k - 1'b1;
            end
        end
    end

    assign o_sts.done = r_done;
    assign o_sts.m    = r_m;

endmodule
`default_nettype wire

[rtl/heightfield_vertex_normals.sv]
// Write beat: the store is written at the accepting edge.
// Out-of-range beat: the error result goes through the output state into the result register; the next beat is taken after it.
// Read beat: the result passes through the row/column divider, the seven height reads on the single store port,
// summing and squaring, the bit-serial exact rounding of the three components in the shared unit, and the result
// register; a new request is taken only after the read result has been loaded into that register.
// Reset: registers to 256/256/256, store zeroed one entry a cycle (all MAX_VERTS entries, 65536 by default) while no request is taken.
`default_nettype none
module heightfield_vertex_normals #(
    parameter int MAX_SIDE  = 256,
    parameter int MAX_VERTS = 65536
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    hvn_req_if.sink   i_req,
    hvn_res_if.source o_res,
    hvn_cfg_if.sink   i_cfg
);
    import hvn_pkg::*;

    localparam int CW   = $clog2(MAX_SIDE + 1);
    localparam int RW   = $clog2(MAX_SIDE);
    localparam int AW   = $clog2(MAX_VERTS);
    localparam int VW   = $clog2(MAX_VERTS + 1);
    localparam int TW0  = (2 * CW > VW) ? 2 * CW : VW;
    localparam int TW   = (TW0 > IDX_W + 1) ? TW0 : IDX_W + 1;
    localparam int NAW  = TW + 1;

    t_state r_state, n_state;

    logic [CX_W-1:0] r_cx, r_cz;
    logic [SP_W-1:0] r_sp;
    logic [CW-1:0]   cx_eff, cz_eff;
    logic [SP_W-1:0] sp_eff;
    logic [TW-1:0]   total_raw, total;
    logic            idx_oob;

    logic [IDX_W-1:0] r_idx;
    logic             r_err;
    logic [2:0]       r_cnt;
    logic             r_go;
    logic             r_zero;
    logic [RW-1:0]    r_row, r_col;
    logic [H_W-1:0]   r_h [NB];
    logic [MAG_W-1:0] r_mag [3];
    logic             r_neg [3];
    logic [SQ_W-1:0]  r_sq [3];
    logic [SUM_W-1:0] r_s;
    logic signed [N_W-1:0] r_res [3];

    logic                  r_ovalid;
    logic signed [N_W-1:0] r_onx, r_ony, r_onz;
    logic [IDX_W-1:0]      r_oecho;
    logic                  r_oerr;

    logic in_ready, in_fire, out_load;
    logic div_start, div_done;
    logic [IDX_W-1:0] div_quot;
    logic [CW-1:0]    div_rem;
    logic rd_en, st_busy;
    logic [H_W-1:0] rd_data;
    logic signed [NAW-1:0] nb_addr;
    logic nb_ok;
    t_norm_cmd norm_cmd;
    t_norm_sts norm_sts;

    logic q1, q2, q3, q4;
    logic signed [11:0] sx_u, sz_u;
    logic [11:0] ax, az;
    logic [2:0] n_tri;
    logic [MAG_W-1:0] sy_m;

    function automatic logic signed [11:0] dif(input logic [H_W-1:0] p,
                                               input logic [H_W-1:0] q);
        return signed'(12'(p)) - signed'(12'(q));
    endfunction

    // effective grid settings
    always_comb begin
        if (r_cx < CX_W'(2))             cx_eff = CW'(2);
        else if (r_cx > CX_W'(MAX_SIDE)) cx_eff = CW'(MAX_SIDE);
        else                             cx_eff = CW'(r_cx);
        if (r_cz < CX_W'(2))             cz_eff = CW'(2);
        else if (r_cz > CX_W'(MAX_SIDE)) cz_eff = CW'(MAX_SIDE);
        else                             cz_eff = CW'(r_cz);
        sp_eff    = (r_sp == '0) ? SP_W'(1) : r_sp;
        total_raw = TW'(cx_eff) * TW'(cz_eff);
        total     = (total_raw > TW'(MAX_VERTS)) ? TW'(MAX_VERTS) : total_raw;
        idx_oob   = TW'(i_req.vertex_index) >= total;
    end

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cx <= CX_W'(256);
            r_cz <= CX_W'(256);
            r_sp <= SP_W'(256);
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_COUNT_X: r_cx <= i_cfg.data[CX_W-1:0];
                CFG_COUNT_Z: r_cz <= i_cfg.data[CX_W-1:0];
                CFG_SPACING: r_sp <= i_cfg.data[SP_W-1:0];
                default: ;
            endcase
        end
    end

    // neighbour order: centre, below, below-right, left, right, above-left, above
    always_comb begin
        nb_addr = signed'(NAW'(r_idx));
        case (r_cnt)
            3'd1:    nb_addr = signed'(NAW'(r_idx)) - signed'(NAW'(cx_eff));
            3'd2:    nb_addr = signed'(NAW'(r_idx)) - signed'(NAW'(cx_eff)) + 2'sd1;
            3'd3:    nb_addr = signed'(NAW'(r_idx)) - 2'sd1;
            3'd4:    nb_addr = signed'(NAW'(r_idx)) + 2'sd1;
            3'd5:    nb_addr = signed'(NAW'(r_idx)) + signed'(NAW'(cx_eff)) - 2'sd1;
            3'd6:    nb_addr = signed'(NAW'(r_idx)) + signed'(NAW'(cx_eff));
            default: nb_addr = signed'(NAW'(r_idx));
        endcase
        nb_ok = (nb_addr >= 0) && (nb_addr < signed'(NAW'(MAX_VERTS)));
    end

    // face-normal sums over the quads that exist around the vertex
    always_comb begin
        q1 = (r_row != '0) && (r_col != '0);
        q2 = (r_row != '0) && (CW'(r_col) + 1'b1 < cx_eff);
        q3 = (CW'(r_row) + 1'b1 < cz_eff) && (r_col != '0);
        q4 = (CW'(r_row) + 1'b1 < cz_eff) && (CW'(r_col) + 1'b1 < cx_eff);
        sx_u = (q1 ? dif(r_h[3], r_h[0]) : 12'sd0)
             + (q2 ? dif(r_h[0], r_h[4]) + dif(r_h[1], r_h[2]) : 12'sd0)
             + (q3 ? dif(r_h[5], r_h[6]) + dif(r_h[3], r_h[0]) : 12'sd0)
             + (q4 ? dif(r_h[0], r_h[4]) : 12'sd0);
        sz_u = (q1 ? dif(r_h[1], r_h[0]) : 12'sd0)
             + (q2 ? dif(r_h[2], r_h[4]) + dif(r_h[1], r_h[0]) : 12'sd0)
             + (q3 ? dif(r_h[0], r_h[6]) + dif(r_h[3], r_h[5]) : 12'sd0)
             + (q4 ? dif(r_h[0], r_h[6]) : 12'sd0);
        n_tri = 3'(q1) + 3'(q4) + 3'({q2, 1'b0}) + 3'({q3, 1'b0});
        ax    = (sx_u < 0) ? unsigned'(-sx_u) : unsigned'(sx_u);
        az    = (sz_u < 0) ? unsigned'(-sz_u) : unsigned'(sz_u);
        sy_m  = MAG_W'(n_tri) * MAG_W'(4'd10) * MAG_W'(sp_eff);
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_fire) begin
                    if (idx_oob)                         n_state = ST_OUT;
                    else if (i_req.req_type == REQ_READ) n_state = ST_DIV;
                end
            end
            ST_DIV:   if (div_done) n_state = ST_FETCH;
            ST_FETCH: if (r_cnt == 3'd7) n_state = ST_SUM;
            ST_SUM:   n_state = ST_SQ;
            ST_SQ:    if (r_cnt == 3'd3) n_state = ST_NORM;
            ST_NORM:  if (norm_sts.done && r_cnt == 3'd2) n_state = ST_OUT;
            ST_OUT:   if (out_load) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        in_ready  = 1'b0;
        rd_en     = 1'b0;
        out_load  = 1'b0;
        unique case (r_state)
            ST_IDLE:  in_ready = !st_busy;
            ST_FETCH: rd_en    = (r_cnt != 3'd7);
            ST_OUT:   out_load = !r_ovalid || o_res.ready;
            default: ;
        endcase
        in_fire   = in_ready && i_req.valid;
        div_start = in_fire && !idx_oob && (i_req.req_type == REQ_READ);
        norm_cmd.start = (r_state == ST_NORM) && r_go;
        norm_cmd.s     = r_s;
        norm_cmd.sq    = r_sq[r_cnt[1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_go <= 1'b0;
        end else if (r_state == ST_SQ && r_cnt == 3'd3) begin
            r_go <= 1'b1;
        end else if (r_state == ST_NORM && norm_sts.done && r_cnt != 3'd2) begin
            r_go <= 1'b1;
        end else begin
            r_go <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                if (in_fire) begin
                    r_idx <= i_req.vertex_index;
                    r_err <= idx_oob;
                    for (int i = 0; i < 3; i++) r_res[i] <= '0;
                end
            end
            ST_DIV: begin
                r_cnt <= '0;
                r_row <= div_quot[RW-1:0];
                r_col <= div_rem[RW-1:0];
            end
            ST_FETCH: begin
                r_cnt  <= r_cnt + 1'b1;
                r_zero <= !nb_ok;
                if (r_cnt != 3'd0) begin
                    r_h[r_cnt - 1'b1] <= r_zero ? '0 : rd_data;
                end
            end
            ST_SUM: begin
                r_cnt    <= '0;
                r_mag[0] <= MAG_W'(ax) << 8;
                r_mag[1] <= sy_m;
                r_mag[2] <= MAG_W'(az) << 8;
                r_neg[0] <= sx_u < 0;
                r_neg[1] <= 1'b0;
                r_neg[2] <= sz_u < 0;
            end
            ST_SQ: begin
                if (r_cnt == 3'd3) begin
                    r_s   <= SUM_W'(r_sq[0]) + SUM_W'(r_sq[1]) + SUM_W'(r_sq[2]);
                    r_cnt <= '0;
                end else begin
                    r_sq[r_cnt[1:0]] <= SQ_W'(r_mag[r_cnt[1:0]]) * SQ_W'(r_mag[r_cnt[1:0]]);
                    r_cnt <= r_cnt + 1'b1;
                end
            end
            ST_NORM: begin
                if (norm_sts.done) begin
                    r_res[r_cnt[1:0]] <= r_neg[r_cnt[1:0]]
                                       ? -signed'(N_W'(norm_sts.m))
                                       : signed'(N_W'(norm_sts.m));
                    r_cnt <= r_cnt + 1'b1;
                end
            end
            ST_OUT: ;
            default: ;
        endcase
    end

    // result register, free to refill once its beat is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (out_load) begin
            r_ovalid <= 1'b1;
        end else if (o_res.ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_onx   <= r_res[0];
            r_ony   <= r_res[1];
            r_onz   <= r_res[2];
            r_oecho <= r_idx;
            r_oerr  <= r_err;
        end
    end

    assign i_req.ready       = in_ready;
    assign o_res.valid       = r_ovalid;
    assign o_res.normal_x    = r_onx;
    assign o_res.normal_y    = r_ony;
    assign o_res.normal_z    = r_onz;
    assign o_res.vertex_echo = r_oecho;
    assign o_res.index_error = r_oerr;

    hvn_store #(
        .DEPTH (MAX_VERTS)
    ) u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (in_fire && !idx_oob && (i_req.req_type == REQ_WRITE)),
        .i_wr_addr (i_req.vertex_index[AW-1:0]),
        .i_wr_data (i_req.height_sample),
        .i_rd_en   (rd_en),
        .i_rd_addr (nb_addr[AW-1:0]),
        .o_rd_data (rd_data),
        .o_busy    (st_busy)
    );

    hvn_div #(
        .NW (IDX_W),
        .DW (CW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (i_req.vertex_index),
        .i_den   (cx_eff),
        .o_done  (div_done),
        .o_quot  (div_quot),
        .o_rem   (div_rem)
    );

    hvn_norm u_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (norm_cmd),
        .o_sts   (norm_sts)
    );

endmodule
`default_nettype wire

[rtl/hvn_checker.sv]
`default_nettype none
module hvn_checker (
    input wire logic                           i_clk,
    input wire logic                           i_rst_n,
    input wire logic                           i_valid,
    input wire logic                           i_ready,
    input wire logic signed [hvn_pkg::N_W-1:0] i_nx,
    input wire logic signed [hvn_pkg::N_W-1:0] i_ny,
    input wire logic signed [hvn_pkg::N_W-1:0] i_nz,
    input wire logic [hvn_pkg::IDX_W-1:0]      i_echo,
    input wire logic                           i_err
);
    import hvn_pkg::*;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid && $stable(i_nx) && $stable(i_ny)
                                && $stable(i_nz) && $stable(i_echo) && $stable(i_err))
        else $error("result beat changed while stalled");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_err |-> i_nx == 0 && i_ny == 0 && i_nz == 0)
        else $error("error beat carries a non-zero normal");

    a_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_err |-> i_ny > 0 && i_ny <= 16'sd16384)
        else $error("normal y component not pointing up");

    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_err |-> i_nx >= -16'sd16384 && i_nx <= 16'sd16384
                              && i_nz >= -16'sd16384 && i_nz <= 16'sd16384)
        else $error("normal component beyond unit range");

endmodule

bind heightfield_vertex_normals hvn_checker u_hvn_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (o_res.valid),
    .i_ready (o_res.ready),
    .i_nx    (o_res.normal_x),
    .i_ny    (o_res.normal_y),
    .i_nz    (o_res.normal_z),
    .i_echo  (o_res.vertex_echo),
    .i_err   (o_res.index_error)
);
`default_nettype wire
